// File: src/window_fifo_min_max_unit_assert.svh
// Assertion macros for the window FIFO min/max unit and its checker
`ifndef WINDOW_FIFO_MIN_MAX_UNIT_ASSERT_SVH
`define WINDOW_FIFO_MIN_MAX_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WFMM_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wfmm assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define WFMM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wfmm assertion failed");

`endif

// File: src/wfmm_pkg.sv
// Shared types and constants of the window FIFO min/max unit
`default_nettype none
package wfmm_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_W     = 32;
	localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int CNT_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t MAX_START = '0;
	localparam sample_t MIN_START = {1'b0, {(SAMPLE_W-1){1'b1}}};

	typedef logic [1:0] func_t;
	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_REMOVE = 2'd1;

	localparam logic STATUS_GOOD = 1'b0;
	localparam logic STATUS_ERR  = 1'b1;

	typedef struct packed {
		func_t   func;
		sample_t value;
	} req_item_t;

	typedef struct packed {
		logic             status;
		sample_t          removed_value;
		logic [OCC_W-1:0] occupancy;
		sample_t          window_max;
		sample_t          window_min;
	} rsp_item_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: src/wfmm_cell.sv
// One queue cell: a stored sample, its occupied flag and the running min/max partial
`default_nettype none
module wfmm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wfmm_pkg::cell_ctl_t ctl,
	input  wfmm_pkg::sample_t   value,
	input  logic                prev_valid,
	input  logic                next_valid,
	input  wfmm_pkg::sample_t   next_data,
	input  wfmm_pkg::sample_t   pin_max,
	input  wfmm_pkg::sample_t   pin_min,
	output logic                valid,
	output wfmm_pkg::sample_t   data,
	output wfmm_pkg::sample_t   pout_max,
	output wfmm_pkg::sample_t   pout_min
);
	import wfmm_pkg::*;

	logic    valid_q;
	sample_t data_q;
	sample_t pmax_q;
	sample_t pmin_q;
	logic    take_new;

	// the first free cell (behind an occupied one, or the head cell) takes the inserted sample
	assign take_new = ctl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			data_q <= next_data;
		end else if (take_new) begin
			data_q <= value;
		end
	end

	// fold this cell into the partial handed down the chain
	always_ff @(posedge clk) begin
		pmax_q <= (valid_q && (data_q > pin_max)) ? data_q : pin_max;
		pmin_q <= (valid_q && (data_q < pin_min)) ? data_q : pin_min;
	end

	assign valid    = valid_q;
	assign data     = data_q;
	assign pout_max = pmax_q;
	assign pout_min = pmin_q;

endmodule
`default_nettype wire

// File: src/wfmm_ctrl.sv
// Sequencer: handshakes, fill count, error check, sweep timing and result register
`default_nettype none
module wfmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wfmm_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wfmm_pkg::rsp_item_t rsp,
	output wfmm_pkg::cell_ctl_t ctl,
	input  wfmm_pkg::sample_t   head_data,
	input  wfmm_pkg::sample_t   sweep_max,
	input  wfmm_pkg::sample_t   sweep_min
);
	import wfmm_pkg::*;

	state_t           state_q;
	state_t           state_nx;
	logic [OCC_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_q;
	logic             status_q;
	sample_t          removed_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	logic             full;
	logic             empty;
	logic             accept;
	logic             err;
	sample_t          removed_nx;
	logic             out_load;

	assign full  = (count_q == OCC_W'(WINDOW_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		state_nx   = state_q;
		req_ready  = 1'b0;
		out_load   = 1'b0;
		ctl        = '0;
		err        = STATUS_GOOD;
		removed_nx = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_nx = ST_SWEEP;
					unique case (req.func)
						FUNC_INSERT: begin
							if (full) begin
								err = STATUS_ERR;
							end else begin
								ctl.push = 1'b1;
							end
						end
						FUNC_REMOVE: begin
							if (empty) begin
								err = STATUS_ERR;
							end else begin
								ctl.pop    = 1'b1;
								removed_nx = head_data;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWEEP: begin
				if (cnt_q == CNT_W'(WINDOW_DEPTH - 1)) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				out_load = !rsp_valid_q || rsp_ready;
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + OCC_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - OCC_W'(1);
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= err;
			removed_q <= removed_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.status        <= status_q;
			rsp_q.removed_value <= removed_q;
			rsp_q.occupancy     <= count_q;
			rsp_q.window_max    <= sweep_max;
			rsp_q.window_min    <= sweep_min;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: src/window_fifo_min_max_unit.sv
// Top level: shifting window queue of samples reporting its min and max
//
//  channel | valid     | ready     | beat
//  request | req_valid | req_ready | req (func, value)
//  result  | rsp_valid | rsp_ready | rsp (status, removed_value, occupancy, window_max,
//          |           |           |      window_min)
//
// A request beat is handled in steps: the cell chain applies the operation at the accept edge,
// the min/max partials ripple one cell per cycle through all WINDOW_DEPTH cells, and the
// result register is loaded once it is free.
// A waiting result does not block the next request; a new result waits in the sequencer
// while the result register is still full. Reset empties the queue; no clearing pass.
`default_nettype none
module window_fifo_min_max_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wfmm_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wfmm_pkg::rsp_item_t rsp
);
	import wfmm_pkg::*;

	cell_ctl_t ctl;
	logic      valid_w [WINDOW_DEPTH];
	sample_t   data_w  [WINDOW_DEPTH];
	sample_t   pmax_w  [WINDOW_DEPTH];
	sample_t   pmin_w  [WINDOW_DEPTH];

	wfmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.ctl       (ctl),
		.head_data (data_w[0]),
		.sweep_max (pmax_w[WINDOW_DEPTH-1]),
		.sweep_min (pmin_w[WINDOW_DEPTH-1])
	);

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		logic    prev_valid;
		logic    next_valid;
		sample_t next_data;
		sample_t pin_max;
		sample_t pin_min;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign pin_max    = MAX_START;
			assign pin_min    = MIN_START;
		end else begin : g_body
			assign prev_valid = valid_w[i-1];
			assign pin_max    = pmax_w[i-1];
			assign pin_min    = pmin_w[i-1];
		end

		if (i == WINDOW_DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_data  = '0;
		end else begin : g_link
			assign next_valid = valid_w[i+1];
			assign next_data  = data_w[i+1];
		end

		wfmm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.value      (req.value),
			.prev_valid (prev_valid),
			.next_valid (next_valid),
			.next_data  (next_data),
			.pin_max    (pin_max),
			.pin_min    (pin_min),
			.valid      (valid_w[i]),
			.data       (data_w[i]),
			.pout_max   (pmax_w[i]),
			.pout_min   (pmin_w[i])
		);
	end

endmodule
`default_nettype wire

// File: src/wfmm_checker.sv
// Port-level checker for the window FIFO min/max unit, bound to the top level
`default_nettype none
`include "window_fifo_min_max_unit_assert.svh"
module wfmm_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  wfmm_pkg::rsp_item_t rsp
);
	import wfmm_pkg::*;

	logic req_beat;
	logic ext_start;
	assign req_beat  = req_valid && req_ready;
	assign ext_start = (rsp.window_max == MAX_START) && (rsp.window_min == MIN_START);

	// a stalled result holds
	`WFMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	// an empty window reports the start values
	`WFMM_ASSERT(a_empty_ext, rsp_valid && rsp.occupancy == '0, ext_start)
	// the maximum search starts from zero
	`WFMM_ASSERT(a_max_nonneg, rsp_valid, !rsp.window_max[SAMPLE_W-1])
	// occupancy never exceeds the depth
	`WFMM_ASSERT(a_occ_range, rsp_valid, rsp.occupancy <= OCC_W'(WINDOW_DEPTH))
	// no second request is taken right after one
	`WFMM_ASSERT_NEXT(a_req_gap, req_beat, !req_ready)

endmodule

bind window_fifo_min_max_unit wfmm_checker u_wfmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
